// ===== rtl/sawle_pkg.sv =====
// shared types, codes and helper functions for the stop-and-wait link endpoint
`timescale 1ns / 1ps
`default_nettype none
package sawle_pkg;

  localparam int unsigned InitLengthDefault = 4;
  localparam int unsigned PosW = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [9:0] AckFrame = 10'h100;
  localparam logic [9:0] AckWord  = 10'h2ff;

  localparam logic [1:0] OpSendByte  = 2'd0;
  localparam logic [1:0] OpRxWord    = 2'd1;
  localparam logic [1:0] OpInitSend  = 2'd2;
  localparam logic [1:0] OpInitAwait = 2'd3;

  localparam logic [3:0] EvNone       = 4'd0;
  localparam logic [3:0] EvByteAcked  = 4'd1;
  localparam logic [3:0] EvByteRx     = 4'd2;
  localparam logic [3:0] EvAckIgnored = 4'd3;
  localparam logic [3:0] EvBusy       = 4'd4;
  localparam logic [3:0] EvInitConf   = 4'd5;
  localparam logic [3:0] EvSyncDone   = 4'd6;
  localparam logic [3:0] EvDiscarded  = 4'd7;
  localparam logic [3:0] EvSyncByte   = 4'd8;

  typedef enum logic [4:0] {
    ModeIdle   = 5'b00001,
    ModeAwait  = 5'b00010,
    ModeISend  = 5'b00100,
    ModeIFinal = 5'b01000,
    ModeIWait  = 5'b10000
  } mode_e;

  // one queued result descriptor; dual marks the two-result init completion
  typedef struct packed {
    logic [9:0] link_word;
    logic       link_word_valid;
    logic [7:0] host_byte;
    logic       host_byte_valid;
    logic [3:0] event_res;
    logic       dual;
  } desc_t;

  function automatic logic [7:0] seq_byte(logic [PosW-1:0] i, logic [3:0] len);
    logic [8:0] sh;
    sh = 9'd2 << i;
    if (({1'b0, i} + 4'd1) >= len) begin
      return 8'd0;
    end
    return sh[7:0];
  endfunction

  function automatic logic [9:0] data_frame(logic [7:0] b);
    return {1'b1, ~b, 1'b0};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sawle_front.sv =====
// front part: takes requests, tracks link mode and builds result descriptors
`timescale 1ns / 1ps
`default_nettype none
module sawle_front import sawle_pkg::*; #(
  parameter int unsigned INIT_LENGTH = InitLengthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  tx_byte_i,
  input  wire logic [31:0] rx_word_i,
  output desc_t            desc_o
);

  localparam logic [3:0] InitLen = 4'(INIT_LENGTH);

  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [9:0]       frame;
  logic [7:0]       rx_b;
  logic [3:0]       pos_next;
  logic             idle;

  assign frame    = ~rx_word_i[31:22];
  assign rx_b     = frame[8:1];
  assign pos_next = {1'b0, pos_q} + 4'd1;
  assign idle     = !(mode_q == ModeAwait || mode_q == ModeISend ||
                      mode_q == ModeIFinal || mode_q == ModeIWait);

  always_comb begin
    mode_d = mode_q;
    pos_d  = pos_q;
    desc_o = '0;
    if (operation_i != OpRxWord) begin
      if (!idle) begin
        desc_o.event_res = EvBusy;
      end else if (operation_i == OpSendByte) begin
        mode_d = ModeAwait;
        desc_o.link_word = data_frame(tx_byte_i);
        desc_o.link_word_valid = 1'b1;
        desc_o.event_res = EvNone;
      end else if (operation_i == OpInitSend) begin
        mode_d = ModeISend;
        pos_d  = '0;
        desc_o.link_word = data_frame(seq_byte('0, InitLen));
        desc_o.link_word_valid = 1'b1;
      end else begin
        mode_d = ModeIWait;
        pos_d  = '0;
      end
    end else if (frame == AckFrame) begin
      case (mode_q)
        ModeAwait: begin
          mode_d = ModeIdle;
          desc_o.event_res = EvByteAcked;
        end
        ModeISend: begin
          desc_o.event_res = EvByteAcked;
          if (pos_next >= InitLen) begin
            mode_d = ModeIFinal;
            pos_d  = '0;
          end else begin
            pos_d = pos_next[PosW-1:0];
            desc_o.link_word = data_frame(seq_byte(pos_next[PosW-1:0], InitLen));
            desc_o.link_word_valid = 1'b1;
          end
        end
        ModeIFinal: begin
          mode_d = ModeIdle;
          desc_o.event_res = EvSyncDone;
        end
        default: begin
          desc_o.event_res = EvAckIgnored;
        end
      endcase
    end else begin
      case (mode_q)
        ModeAwait, ModeISend, ModeIFinal: begin
          desc_o.event_res = EvDiscarded;
        end
        ModeIWait: begin
          desc_o.link_word = AckWord;
          desc_o.link_word_valid = 1'b1;
          desc_o.event_res = EvSyncByte;
          if (rx_b == seq_byte(pos_q, InitLen)) begin
            if (pos_next >= InitLen) begin
              mode_d = ModeIdle;
              pos_d  = '0;
              desc_o.dual = 1'b1;
            end else begin
              pos_d = pos_next[PosW-1:0];
            end
          end else begin
            pos_d = '0;
          end
        end
        default: begin
          desc_o.link_word = AckWord;
          desc_o.link_word_valid = 1'b1;
          desc_o.host_byte = rx_b;
          desc_o.host_byte_valid = 1'b1;
          desc_o.event_res = EvByteRx;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      pos_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sawle_queue.sv =====
// short descriptor queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module sawle_queue import sawle_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t push_data_i,
  output logic       ready_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output desc_t      head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  desc_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    count_q;
  logic             do_push, do_pop;

  assign ready_o = count_q != PtrW'(0) + (PtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sawle_back.sv =====
// back part: expands descriptors into result words behind an output register
`timescale 1ns / 1ps
`default_nettype none
module sawle_back import sawle_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire desc_t       q_head_i,
  output logic             q_pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [23:0]      m_data_o,
  output logic             m_last_o
);

  logic        valid_q;
  logic        phase_q;
  logic [23:0] data_q;
  logic        last_q;
  logic        load;
  logic [3:0]  ev;

  assign load    = q_valid_i && (!valid_q || m_ready_i);
  // the dual descriptor stays at the head until its second word is loaded
  assign q_pop_o = load && (!q_head_i.dual || phase_q);
  assign ev      = (q_head_i.dual && phase_q) ? EvInitConf : q_head_i.event_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= q_head_i.dual && !phase_q;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {ev, q_head_i.host_byte_valid, q_head_i.host_byte,
                 q_head_i.link_word_valid, q_head_i.link_word};
      last_q <= !q_head_i.dual || phase_q;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

endmodule
`default_nettype wire

// ===== rtl/stop_and_wait_link_endpoint.sv =====
// top level of the stop-and-wait link endpoint
// usage:
// requests enter on the s_axis channel: tuser carries the operation (send host
// byte, receiver word, send init sequence, await init sequence), tdata carries
// the byte to send in bits 7:0 and the raw receiver word in bits 39:8.
// results leave on the m_axis channel, one word per result; tlast marks the
// final result of a request. only the last matched init byte gives two results.
// one request is taken every cycle while the descriptor queue has room; the
// link mode update sits in the front stage, so each request sees the state
// left by the one before it.
// results pass through the queue, then the output register; throughput is
// one result per cycle while the receiver is ready, limited by the single
// output register; the two-result request holds the queue head until its
// second result is loaded. when the receiver stalls the output register
// holds, the two-entry queue fills and tready falls until a result is taken.
// reset clears the link mode to idle, the sequence position and the queue.
`timescale 1ns / 1ps
`default_nettype none
module stop_and_wait_link_endpoint import sawle_pkg::*; #(
  parameter int unsigned INIT_LENGTH = InitLengthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // tx_byte[7:0], rx_word[39:8]
  input  wire logic [1:0]  s_axis_tuser_i,  // operation[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // link_word[9:0], link_word_valid[10], host_byte[18:11], host_byte_valid[19],
  // event_res[23:20]
  output logic [23:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  desc_t front_desc;
  desc_t q_head;
  logic  q_ready, q_valid, q_pop, accept;

  assign s_axis_tready_o = q_ready;
  assign accept          = s_axis_tvalid_i && q_ready;

  sawle_front #(
    .INIT_LENGTH(INIT_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (s_axis_tuser_i),
    .tx_byte_i   (s_axis_tdata_i[7:0]),
    .rx_word_i   (s_axis_tdata_i[39:8]),
    .desc_o      (front_desc)
  );

  sawle_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_desc),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  sawle_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

  // a received byte is only ever reported with the byte-received event
  a_host_byte_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[19]) |-> (m_axis_tdata_o[23:20] == EvByteRx))
    else $error("host byte valid without byte-received event");

  // a non-final result is the sync byte ack and is followed by the init confirm
  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tdata_o[23:20] == EvSyncByte))
    else $error("non-final result is not a sync byte");

  a_second_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && m_axis_tlast_o && m_axis_tdata_o[23:20] == EvInitConf))
    else $error("init confirm did not follow sync byte ack");

  // nothing to transmit means an all-zero link word
  a_idle_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[10]) |-> (m_axis_tdata_o[9:0] == 10'd0))
    else $error("link word set without link word valid");

endmodule
`default_nettype wire

// ===== dv/tb_stop_and_wait_link_endpoint.sv =====
// self-checking testbench for the stop-and-wait link endpoint
`timescale 1ns / 1ps
module tb_stop_and_wait_link_endpoint;
  import sawle_pkg::*;

  localparam int unsigned InitLen = InitLengthDefault;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomRequests = 500;

  typedef struct {
    logic [9:0] link_word;
    logic       link_word_valid;
    logic [7:0] host_byte;
    logic       host_byte_valid;
    logic [3:0] event_res;
    logic       last;
  } link_result_t;

  // mirrors the endpoint state and holds the results still owed by the block
  class link_result_board;
    mode_e           link_mode;
    logic [2:0]      seq_pos;
    link_result_t    awaited_results[$];
    int              mismatches;
    int              results_seen;
    int              event_count[16];

    function new();
      link_mode    = ModeIdle;
      seq_pos      = '0;
      mismatches   = 0;
      results_seen = 0;
      foreach (event_count[i]) event_count[i] = 0;
    endfunction

    function automatic logic [7:0] init_byte(logic [2:0] idx);
      logic [8:0] shifted;
      shifted = 9'd2 << idx;
      if (int'(idx) + 1 >= int'(InitLen)) return 8'h00;
      return shifted[7:0];
    endfunction

    function automatic logic [9:0] frame_of(logic [7:0] b);
      return 10'h200 | {1'b0, ~b, 1'b0};
    endfunction

    function void owe(logic [9:0] w, logic wv, logic [7:0] hb, logic hv,
                      logic [3:0] ev, logic last);
      link_result_t r;
      r.link_word       = w;
      r.link_word_valid = wv;
      r.host_byte       = hb;
      r.host_byte_valid = hv;
      r.event_res       = ev;
      r.last            = last;
      awaited_results.push_back(r);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void note_request(logic [1:0] op, logic [7:0] txb, logic [31:0] rx);
      logic [9:0] frame;
      logic [7:0] b;
      frame = ~rx[31:22];
      b     = frame[8:1];
      if (op != OpRxWord) begin
        if (link_mode != ModeIdle) begin
          owe('0, 1'b0, '0, 1'b0, EvBusy, 1'b1);
        end else if (op == OpSendByte) begin
          link_mode = ModeAwait;
          owe(frame_of(txb), 1'b1, '0, 1'b0, EvNone, 1'b1);
        end else if (op == OpInitSend) begin
          link_mode = ModeISend;
          seq_pos   = '0;
          owe(frame_of(init_byte(3'd0)), 1'b1, '0, 1'b0, EvNone, 1'b1);
        end else begin
          link_mode = ModeIWait;
          seq_pos   = '0;
          owe('0, 1'b0, '0, 1'b0, EvNone, 1'b1);
        end
      end else if (frame == AckFrame) begin
        case (link_mode)
          ModeAwait: begin
            link_mode = ModeIdle;
            owe('0, 1'b0, '0, 1'b0, EvByteAcked, 1'b1);
          end
          ModeISend: begin
            if (int'(seq_pos) + 1 >= int'(InitLen)) begin
              link_mode = ModeIFinal;
              seq_pos   = '0;
              owe('0, 1'b0, '0, 1'b0, EvByteAcked, 1'b1);
            end else begin
              seq_pos = seq_pos + 3'd1;
              owe(frame_of(init_byte(seq_pos)), 1'b1, '0, 1'b0, EvByteAcked, 1'b1);
            end
          end
          ModeIFinal: begin
            link_mode = ModeIdle;
            owe('0, 1'b0, '0, 1'b0, EvSyncDone, 1'b1);
          end
          default: begin
            owe('0, 1'b0, '0, 1'b0, EvAckIgnored, 1'b1);
          end
        endcase
      end else if (link_mode inside {ModeAwait, ModeISend, ModeIFinal}) begin
        owe('0, 1'b0, '0, 1'b0, EvDiscarded, 1'b1);
      end else if (link_mode == ModeIWait) begin
        if (b == init_byte(seq_pos)) begin
          if (int'(seq_pos) + 1 >= int'(InitLen)) begin
            // last sync byte: its own ack, then the extra confirming ack
            link_mode = ModeIdle;
            seq_pos   = '0;
            owe(AckWord, 1'b1, '0, 1'b0, EvSyncByte, 1'b0);
            owe(AckWord, 1'b1, '0, 1'b0, EvInitConf, 1'b1);
            return;
          end
          seq_pos = seq_pos + 3'd1;
        end else begin
          seq_pos = '0;
        end
        owe(AckWord, 1'b1, '0, 1'b0, EvSyncByte, 1'b1);
      end else begin
        owe(AckWord, 1'b1, b, 1'b1, EvByteRx, 1'b1);
      end
    endfunction

    task check_result(logic [23:0] d, logic last);
      link_result_t e;
      results_seen++;
      event_count[d[23:20]]++;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result data %h last %b", d, last));
        return;
      end
      e = awaited_results.pop_front();
      if (d[9:0] !== e.link_word || d[10] !== e.link_word_valid ||
          d[18:11] !== e.host_byte || d[19] !== e.host_byte_valid ||
          d[23:20] !== e.event_res || last !== e.last) begin
        report($sformatf({"word %h/%h wv %b/%b byte %h/%h bv %b/%b ev %0d/%0d",
                          " last %b/%b (got/exp)"},
                         d[9:0], e.link_word, d[10], e.link_word_valid,
                         d[18:11], e.host_byte, d[19], e.host_byte_valid,
                         d[23:20], e.event_res, last, e.last));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [23:0] m_axis_tdata_o;
  wire         m_axis_tlast_o;

  link_result_board sb = new();
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          requests_sent = 0;
  int          requests_taken = 0;

  stop_and_wait_link_endpoint #(
    .INIT_LENGTH(InitLen)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
    end
  end

  // both handshakes observed at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        sb.note_request(s_tuser, s_tdata[7:0], s_tdata[39:8]);
        requests_taken++;
      end
      if (m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles", StallLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] rx_for(logic [9:0] frame);
    logic [21:0] filler;
    filler = 22'($urandom());
    return {~frame, filler};
  endfunction

  // data frame for a byte; the outer frame bits are random but never form an ack
  function automatic logic [31:0] rx_data(logic [7:0] b);
    logic [9:0] f;
    f = {1'($urandom()), b, 1'($urandom())};
    if (f == AckFrame) f[0] = 1'b1;
    return rx_for(f);
  endfunction

  task automatic push_request(input logic [1:0] op, input logic [7:0] txb,
                              input logic [31:0] rx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rx, txb};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    requests_sent++;
  endtask

  task automatic send_ack();
    push_request(OpRxWord, 8'($urandom()), rx_for(AckFrame));
  endtask

  task automatic send_data(input logic [7:0] b);
    push_request(OpRxWord, 8'($urandom()), rx_data(b));
  endtask

  task automatic send_busy_op();
    logic [1:0] op;
    case ($urandom_range(0, 2))
      0: op = OpSendByte;
      1: op = OpInitSend;
      default: op = OpInitAwait;
    endcase
    push_request(op, 8'($urandom()), $urandom());
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // stray request while a transfer is outstanding
  task automatic wait_noise();
    if ($urandom_range(0, 1) == 0) send_data(8'($urandom()));
    else send_busy_op();
  endtask

  task automatic run_init_wait();
    int k;
    logic [7:0] wrong;
    push_request(OpInitAwait, 8'($urandom()), $urandom());
    k = 0;
    while (k < int'(InitLen)) begin
      case ($urandom_range(0, 19))
        0: begin
          wrong = sb.init_byte(3'(k)) ^ 8'($urandom_range(1, 255));
          send_data(wrong);
          k = 0;
        end
        1: send_ack();
        2: send_busy_op();
        default: begin
          send_data(sb.init_byte(3'(k)));
          k++;
        end
      endcase
    end
  endtask

  task automatic run_init_send();
    for (int k = 0; k <= int'(InitLen); k++) begin
      if ($urandom_range(0, 4) == 0) wait_noise();
      send_ack();
    end
  endtask

  // bring the endpoint back to idle after random requests
  task automatic settle();
    int tries;
    tries = 0;
    wait_drained();
    while (sb.link_mode != ModeIdle && tries < 8) begin
      if (sb.link_mode == ModeIWait) begin
        for (int k = 0; k < int'(InitLen); k++) send_data(sb.init_byte(3'(k)));
      end else begin
        send_ack();
      end
      wait_drained();
      tries++;
    end
  endtask

  initial begin
    int pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle traffic, sync wait with a mismatch, host send, init send
    push_request(OpRxWord, 8'h00, {~{1'b0, 8'h00, 1'b1}, 22'h3fffff});
    push_request(OpRxWord, 8'hff, {~{1'b1, 8'hff, 1'b1}, 22'h000000});
    push_request(OpRxWord, 8'h5a, {~{1'b0, 8'h80, 1'b1}, 22'h155555});
    send_ack();
    push_request(OpInitAwait, 8'h00, 32'h0);
    push_request(OpSendByte, 8'hff, 32'hffffffff);
    push_request(OpInitSend, 8'h00, 32'h0);
    push_request(OpInitAwait, 8'h00, 32'h0);
    send_ack();
    send_data(8'h02);
    send_data(8'h04);
    send_data(8'h55);
    for (int k = 0; k < int'(InitLen); k++) send_data(sb.init_byte(3'(k)));
    push_request(OpSendByte, 8'h00, 32'h0);
    send_data(8'h33);
    push_request(OpInitAwait, 8'h00, 32'h0);
    send_ack();
    push_request(OpSendByte, 8'hff, 32'h0);
    send_ack();
    push_request(OpInitSend, 8'h00, 32'hffffffff);
    send_data(8'h02);
    for (int k = 0; k < int'(InitLen); k++) send_ack();
    send_data(8'h00);
    send_ack();

    // hold the sender until the block has answered everything
    wait_drained();

    while (requests_sent < 25 + int'(RandomRequests)) begin
      calm = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        wait_drained();
      end else if (pick < 32) begin
        push_request(OpSendByte, 8'($urandom()), $urandom());
        repeat ($urandom_range(0, 2)) wait_noise();
        send_ack();
      end else if (pick < 52) begin
        push_request(OpInitSend, 8'($urandom()), $urandom());
        run_init_send();
      end else if (pick < 72) begin
        run_init_wait();
      end else if (pick < 90) begin
        if ($urandom_range(0, 3) == 0) send_ack();
        else send_data(8'($urandom()));
      end else begin
        repeat ($urandom_range(1, 4)) push_request(2'($urandom()), 8'($urandom()), $urandom());
        settle();
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d requests and %0d results over idle, host send, init send",
             requests_taken, sb.results_seen);
    $display("and init wait traffic; events none..sync byte: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.event_count[0], sb.event_count[1], sb.event_count[2], sb.event_count[3],
             sb.event_count[4], sb.event_count[5], sb.event_count[6], sb.event_count[7],
             sb.event_count[8]);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== stop_and_wait_link_endpoint.f =====
rtl/sawle_pkg.sv
rtl/sawle_front.sv
rtl/sawle_queue.sv
rtl/sawle_back.sv
rtl/stop_and_wait_link_endpoint.sv
dv/tb_stop_and_wait_link_endpoint.sv
